// ===== rtl/core/ccl_pkg.sv =====
// shared widths, codes and defaults for the cursor character list
package ccl_pkg;

  localparam int LEN_W = 7;
  localparam int CHAR_W = 8;
  localparam int OP_W = 3;
  localparam int ST_W = 2;

  localparam int CAPACITY_DEFAULT = 64;
  localparam logic [LEN_W-1:0] MAX_SIZE_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_REPLACE = 3'd2,
    OP_FORWARD = 3'd3,
    OP_BACK    = 3'd4,
    OP_START   = 3'd5,
    OP_END     = 3'd6,
    OP_CLEAR   = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_REFUSED  = 2'd2,
    ST_BOUNDARY = 2'd3
  } status_t;

endpackage

// ===== rtl/core/cursor_char_list.sv =====
// top level of the cursor character list: limit register, sequencer and store
//
// channel   direction  signals                                         handshake
// in        input      operation, new_char                             in_valid / in_ready
// out       output     status, list_length, cursor_pos,                out_valid / out_ready
//                      char_before_cursor, is_empty, is_full
// config    input      cfg_wdata (max_size)                            cfg_we, no wait
//
// an item runs the shift loop, a read and a write per character moved, then fetch and
// load: insert moves length - cursor characters, remove moves length - cursor; insert
// and replace add a store write step.
// reset empties the list, puts the cursor at 0, selects append mode and sets max_size 64.
// a new transaction is taken as soon as the sequencer is idle; a held result only
// stalls the sequencer at its last step.
module cursor_char_list #(
  parameter int CAPACITY = ccl_pkg::CAPACITY_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ccl_pkg::LEN_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ccl_pkg::OP_W-1:0]   operation,
  input  logic [ccl_pkg::CHAR_W-1:0] new_char,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ccl_pkg::ST_W-1:0]   status,
  output logic [ccl_pkg::LEN_W-1:0]  list_length,
  output logic [ccl_pkg::LEN_W-1:0]  cursor_pos,
  output logic [ccl_pkg::CHAR_W-1:0] char_before_cursor,
  output logic                       is_empty,
  output logic                       is_full
);

  localparam int ADDR_W = $clog2(CAPACITY);

  logic [ccl_pkg::LEN_W-1:0] max_size;
  logic mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ccl_pkg::CHAR_W-1:0] mem_wdata;
  logic mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ccl_pkg::CHAR_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= ccl_pkg::MAX_SIZE_RESET;
    end else if (cfg_we) begin
      max_size <= cfg_wdata;
    end
  end

  ccl_ctrl #(
    .CAPACITY(CAPACITY),
    .ADDR_W(ADDR_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .max_size(max_size),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .new_char(new_char),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .list_length(list_length),
    .cursor_pos(cursor_pos),
    .char_before_cursor(char_before_cursor),
    .is_empty(is_empty),
    .is_full(is_full),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  ccl_store #(
    .DEPTH(CAPACITY),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

// ===== rtl/core/ccl_store.sv =====
// character store, one write port and one registered read port
module ccl_store #(
  parameter int DEPTH = ccl_pkg::CAPACITY_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [ccl_pkg::CHAR_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [ccl_pkg::CHAR_W-1:0] rdata
);

  logic [ccl_pkg::CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ccl_ctrl.sv =====
// sequencer: list state, shift loop over the store, result register
module ccl_ctrl #(
  parameter int CAPACITY = ccl_pkg::CAPACITY_DEFAULT,
  parameter int ADDR_W = $clog2(CAPACITY)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ccl_pkg::LEN_W-1:0]  max_size,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ccl_pkg::OP_W-1:0]   operation,
  input  logic [ccl_pkg::CHAR_W-1:0] new_char,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ccl_pkg::ST_W-1:0]   status,
  output logic [ccl_pkg::LEN_W-1:0]  list_length,
  output logic [ccl_pkg::LEN_W-1:0]  cursor_pos,
  output logic [ccl_pkg::CHAR_W-1:0] char_before_cursor,
  output logic                       is_empty,
  output logic                       is_full,
  output logic                       mem_we,
  output logic [ADDR_W-1:0]          mem_waddr,
  output logic [ccl_pkg::CHAR_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [ADDR_W-1:0]          mem_raddr,
  input  logic [ccl_pkg::CHAR_W-1:0] mem_rdata
);

  localparam int LEN_W = ccl_pkg::LEN_W;
  localparam int CAP_CLIP = (CAPACITY < 127) ? CAPACITY : 127;
  localparam logic [LEN_W-1:0] CAP_LIM = LEN_W'(CAP_CLIP);
  localparam logic [LEN_W-1:0] ONE = LEN_W'(1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SHR   = 7'b0000010,
    S_SHW   = 7'b0000100,
    S_PUT   = 7'b0001000,
    S_FETCH = 7'b0010000,
    S_LOAD  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [LEN_W-1:0] length, length_next;
  logic [LEN_W-1:0] cursor, cursor_next;
  logic mode, mode_next;
  logic [LEN_W-1:0] ptr, ptr_next;
  logic [LEN_W-1:0] stop, stop_next;
  logic dir_right, dir_right_next;
  logic [LEN_W-1:0] put_addr, put_addr_next;
  logic [ccl_pkg::CHAR_W-1:0] put_data, put_data_next;
  ccl_pkg::status_t stat, stat_next;
  logic out_valid_next;
  logic load_out;

  logic [LEN_W-1:0] lim;
  logic [LEN_W-1:0] cur_m1;
  logic [LEN_W-1:0] ptr_step;
  ccl_pkg::op_t op;

  assign lim = (max_size < CAP_LIM) ? max_size : CAP_LIM;
  assign cur_m1 = cursor - ONE;
  assign ptr_step = dir_right ? (ptr - ONE) : (ptr + ONE);
  assign op = ccl_pkg::op_t'(operation);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    length_next = length;
    cursor_next = cursor;
    mode_next = mode;
    ptr_next = ptr;
    stop_next = stop;
    dir_right_next = dir_right;
    put_addr_next = put_addr;
    put_data_next = put_data;
    stat_next = stat;
    out_valid_next = out_valid && !out_ready;
    load_out = 1'b0;
    mem_we = 1'b0;
    mem_waddr = ADDR_W'(put_addr);
    mem_wdata = put_data;
    mem_re = 1'b0;
    mem_raddr = ADDR_W'(cur_m1);

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          stat_next = ccl_pkg::ST_OK;
          put_data_next = new_char;
          state_next = S_FETCH;
          case (op)
            ccl_pkg::OP_INSERT: begin
              if (length >= lim) begin
                stat_next = ccl_pkg::ST_FULL;
              end else if (!mode && cursor != length) begin
                stat_next = ccl_pkg::ST_REFUSED;
              end else begin
                ptr_next = length;
                stop_next = cursor;
                dir_right_next = 1'b1;
                put_addr_next = cursor;
                length_next = length + ONE;
                cursor_next = cursor + ONE;
                state_next = (length != cursor) ? S_SHR : S_PUT;
              end
            end
            ccl_pkg::OP_REMOVE: begin
              if (cursor == '0) begin
                stat_next = ccl_pkg::ST_BOUNDARY;
              end else begin
                ptr_next = cursor;
                stop_next = length;
                dir_right_next = 1'b0;
                length_next = length - ONE;
                cursor_next = cur_m1;
                state_next = (cursor != length) ? S_SHR : S_FETCH;
              end
            end
            ccl_pkg::OP_REPLACE: begin
              if (cursor == '0) begin
                stat_next = ccl_pkg::ST_BOUNDARY;
              end else begin
                put_addr_next = cur_m1;
                state_next = S_PUT;
              end
            end
            ccl_pkg::OP_FORWARD: begin
              if (cursor >= length) begin
                stat_next = ccl_pkg::ST_BOUNDARY;
              end else begin
                cursor_next = cursor + ONE;
              end
            end
            ccl_pkg::OP_BACK: begin
              if (cursor == '0) begin
                stat_next = ccl_pkg::ST_BOUNDARY;
              end else begin
                cursor_next = cur_m1;
              end
            end
            ccl_pkg::OP_START: begin
              mode_next = 1'b1;
              cursor_next = '0;
            end
            ccl_pkg::OP_END: begin
              mode_next = 1'b0;
              cursor_next = length;
            end
            default: begin
              length_next = '0;
              cursor_next = '0;
            end
          endcase
        end
      end
      S_SHR: begin
        mem_re = 1'b1;
        mem_raddr = dir_right ? ADDR_W'(ptr - ONE) : ADDR_W'(ptr);
        state_next = S_SHW;
      end
      S_SHW: begin
        mem_we = 1'b1;
        mem_waddr = dir_right ? ADDR_W'(ptr) : ADDR_W'(ptr - ONE);
        mem_wdata = mem_rdata;
        ptr_next = ptr_step;
        if (ptr_step != stop) begin
          state_next = S_SHR;
        end else begin
          state_next = dir_right ? S_PUT : S_FETCH;
        end
      end
      S_PUT: begin
        mem_we = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        mem_re = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid || out_ready) begin
          load_out = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      length <= '0;
      cursor <= '0;
      mode <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      length <= length_next;
      cursor <= cursor_next;
      mode <= mode_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    stop <= stop_next;
    dir_right <= dir_right_next;
    put_addr <= put_addr_next;
    put_data <= put_data_next;
    stat <= stat_next;
    if (load_out) begin
      status <= stat;
      list_length <= length;
      cursor_pos <= cursor;
      char_before_cursor <= (cursor == '0) ? '0 : mem_rdata;
      is_empty <= (length == '0);
      is_full <= (length >= lim);
    end
  end

endmodule
